>>> src/mic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the multiset intersection counter.
// ----------------------------------------------------------------------------
package mic_pkg;

	localparam int MIC_ENTRIES    = 64;
	localparam int MIC_COUNT_BITS = 16;
	localparam int MIC_VALUE_BITS = 32;

	localparam logic [MIC_COUNT_BITS-1:0] MIC_COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PROBE = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic                      valid;
		cmd_t                      cmd;
		logic [MIC_VALUE_BITS-1:0] value;
		logic                      matched;
		logic                      claimed;
	} token_t;

	typedef struct packed {
		logic valid;
		logic commit;
	} resolve_t;

endpackage

>>> src/mic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_cell
// One table entry: a key and its count, passing the command token onward.
// ----------------------------------------------------------------------------
module mic_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mic_pkg::token_t   tok_in,
	input  mic_pkg::resolve_t res,
	output mic_pkg::token_t   tok_out
);
	import mic_pkg::*;

	logic [MIC_VALUE_BITS-1:0] key_q;
	logic [MIC_COUNT_BITS-1:0] count_q;
	logic [MIC_COUNT_BITS-1:0] count_nxt;
	logic                      pend_q;
	logic                      pend_nxt;
	logic                      key_we;
	logic                      live;
	logic                      match;
	token_t                    tok_q;
	token_t                    tok_nxt;

	assign live  = (count_q != '0);
	assign match = live && (key_q == tok_in.value);

	always_comb begin
		tok_nxt   = tok_in;
		count_nxt = count_q;
		pend_nxt  = pend_q;
		key_we    = 1'b0;
		if (res.valid) begin
			if (pend_q && res.commit) begin
				count_nxt = MIC_COUNT_BITS'(1);
			end
			pend_nxt = 1'b0;
		end
		if (tok_in.valid) begin
			case (tok_in.cmd)
				CMD_LOAD: begin
					if (!tok_in.matched && match) begin
						if (count_q != MIC_COUNT_MAX) begin
							count_nxt = count_q + MIC_COUNT_BITS'(1);
						end
						tok_nxt.matched = 1'b1;
					end else if (!tok_in.matched && !tok_in.claimed && !live) begin
						key_we          = 1'b1;
						pend_nxt        = 1'b1;
						tok_nxt.claimed = 1'b1;
					end
				end
				CMD_PROBE: begin
					if (!tok_in.matched && match) begin
						count_nxt       = count_q - MIC_COUNT_BITS'(1);
						tok_nxt.matched = 1'b1;
					end
				end
				CMD_CLEAR: begin
					count_nxt = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			count_q <= count_nxt;
			pend_q  <= pend_nxt;
			tok_q   <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q <= tok_in.value;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> src/multiset_intersection_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_intersection_counter
// Counts loaded values in a row of key cells, consumes them on probes and clears them all on a clear.
// ----------------------------------------------------------------------------
//  channel  | handshake       | words
//  command  | start / busy    | command, value
//  result   | strobe          | hit, match_value, overflow
//
// A command word walks the row of MIC_ENTRIES cells, one cell per cycle.
// The result is registered from the word as it leaves the last cell, and no new
// word is taken while busy is high, that is until the word in flight has left
// the row. A load that claims a free cell is committed or dropped when the word
// leaves the row. Reset frees every entry at once.
// The receiver cannot stall, so the strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module multiset_intersection_counter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            command,
	input  logic signed [mic_pkg::MIC_VALUE_BITS-1:0] value,
	output logic                                  strobe,
	output logic                                  hit,
	output logic signed [mic_pkg::MIC_VALUE_BITS-1:0] match_value,
	output logic                                  overflow
);
	import mic_pkg::*;

	token_t   tok [MIC_ENTRIES+1];
	token_t   last;
	resolve_t res;
	logic     busy_q;
	logic     strobe_q;
	logic     hit_q;
	logic     ovf_q;
	logic [MIC_VALUE_BITS-1:0] mval_q;

	assign tok[0].valid   = start && !busy_q;
	assign tok[0].cmd     = cmd_t'(command);
	assign tok[0].value   = value;
	assign tok[0].matched = 1'b0;
	assign tok[0].claimed = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < MIC_ENTRIES; gi++) begin : g_cell
			mic_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (tok[gi]),
				.res    (res),
				.tok_out(tok[gi+1])
			);
		end
	endgenerate

	assign last       = tok[MIC_ENTRIES];
	assign res.valid  = last.valid;
	assign res.commit = (last.cmd == CMD_LOAD) && !last.matched && last.claimed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
			hit_q    <= 1'b0;
			ovf_q    <= 1'b0;
			mval_q   <= '0;
		end else begin
			strobe_q <= last.valid;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (last.valid) begin
				busy_q <= 1'b0;
			end
			if (last.valid) begin
				hit_q  <= (last.cmd == CMD_PROBE) && last.matched;
				ovf_q  <= (last.cmd == CMD_LOAD) && !last.matched && !last.claimed;
				mval_q <= ((last.cmd == CMD_PROBE) && last.matched) ? last.value : '0;
			end
		end
	end

	assign busy        = busy_q;
	assign strobe      = strobe_q;
	assign hit         = hit_q;
	assign overflow    = ovf_q;
	assign match_value = mval_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while still busy");

	a_hit_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(hit && overflow))
		else $error("hit and overflow in the same result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !hit |-> match_value == '0)
		else $error("match value nonzero without a hit");

endmodule
